// ===== hw/rtl/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int TIME_BITS   = 32;
    localparam int STAMP_BITS  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [7:0]  DEBOUNCE_RST     = 8'd50;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [15:0] DOUBLE_CLICK_RST = 16'd500;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEBOUNCE     = 2'd0,
        CFG_LONG_PRESS   = 2'd1,
        CFG_DOUBLE_CLICK = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_TICK    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_LONG   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HELD   = 2'd1,
        PH_WAIT   = 2'd2,
        PH_SECOND = 2'd3
    } t_phase;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        t_action action;
        t_time   stamp;
    } t_item;

    typedef struct packed {
        logic [7:0]  debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] double_click_ms;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

// ===== hw/rtl/button_click_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Debounces timestamped button edges and sorts gestures into single clicks,
// double clicks and long presses.
// ----------------------------------------------------------------------------
// Takes one transfer per clock cycle when not stalled; a result is registered
// in the output stage after its transfer passes the queue. The back end's
// gesture state update runs once per cycle unless stalled and sets the rate;
// a two-entry queue decouples input from output so either side can stall.
// Config writes go to debounce_ms, long_press_ms and double_click_ms at
// indexes 0, 1 and 2; write them only while no gesture work is in flight.
module button_click_classifier_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bcc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [bcc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_in_action,
    input  logic [bcc_pkg::STAMP_BITS-1:0]    i_in_stamp,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_out_click_kind,
    output logic [bcc_pkg::STAMP_BITS-1:0]    o_out_press_time
);
    import bcc_pkg::*;

    t_cfg      r_cfg;
    t_q_status q_status;
    t_item     fe_item, q_item;
    logic      fe_push, be_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms     <= DEBOUNCE_RST;
            r_cfg.long_press_ms   <= LONG_PRESS_RST;
            r_cfg.double_click_ms <= DOUBLE_CLICK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:     r_cfg.debounce_ms     <= i_cfg_data[7:0];
                CFG_LONG_PRESS:   r_cfg.long_press_ms   <= i_cfg_data;
                CFG_DOUBLE_CLICK: r_cfg.double_click_ms <= i_cfg_data;
                default:          r_cfg                 <= r_cfg;
            endcase
        end
    end

    bcc_front u_front (
        .i_valid    (i_in_valid),
        .i_action   (i_in_action),
        .i_stamp    (i_in_stamp),
        .i_q_status (q_status),
        .o_stall    (o_in_stall),
        .o_push     (fe_push),
        .o_item     (fe_item)
    );

    bcc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fe_push),
        .i_item   (fe_item),
        .i_pop    (be_pop),
        .o_item   (q_item),
        .o_status (q_status)
    );

    bcc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_status.valid),
        .i_item       (q_item),
        .o_pop        (be_pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_click_kind (o_out_click_kind),
        .o_press_time (o_out_press_time)
    );

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(q_status.valid))
        else $error("result without a queued item");

    a_push_fills_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fe_push && !q_status.valid) |=> q_status.valid)
        else $error("pushed item lost");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        be_pop |-> q_status.valid)
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/bcc_front.sv =====
// ----------------------------------------------------------------------------
// bcc_front
// Input side: takes transfers, decodes the action and pushes edges and ticks
// into the queue. Unused action codes are dropped here.
// ----------------------------------------------------------------------------
module bcc_front (
    input  logic                           i_valid,
    input  logic [1:0]                     i_action,
    input  logic [bcc_pkg::STAMP_BITS-1:0] i_stamp,
    input  bcc_pkg::t_q_status             i_q_status,
    output logic                           o_stall,
    output logic                           o_push,
    output bcc_pkg::t_item                 o_item
);
    import bcc_pkg::*;

    logic known;

    always_comb begin
        o_item.stamp  = t_time'(i_stamp);
        o_item.action = ACT_TICK;
        known         = 1'b1;
        unique case (i_action)
            ACT_PRESS:   o_item.action = ACT_PRESS;
            ACT_RELEASE: o_item.action = ACT_RELEASE;
            ACT_TICK:    o_item.action = ACT_TICK;
            default:     known = 1'b0;
        endcase
    end

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full && known;

endmodule

// ===== hw/rtl/bcc_queue.sv =====
// ----------------------------------------------------------------------------
// bcc_queue
// Short FIFO between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module bcc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bcc_pkg::t_item      i_item,
    input  logic                i_pop,
    output bcc_pkg::t_item      o_item,
    output bcc_pkg::t_q_status  o_status
);
    import bcc_pkg::*;

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count,  n_count;
    logic                 do_pop;

    assign do_pop = i_pop && (r_count != '0);

    function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
        logic [QPTR_BITS-1:0] r;
        if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));

endmodule

// ===== hw/rtl/bcc_back.sv =====
// ----------------------------------------------------------------------------
// bcc_back
// Gesture state machine: debounce, phase tracking and classification, with a
// registered output stage.
// ----------------------------------------------------------------------------
module bcc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bcc_pkg::t_cfg                  i_cfg,
    input  logic                           i_q_valid,
    input  bcc_pkg::t_item                 i_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_click_kind,
    output logic [bcc_pkg::STAMP_BITS-1:0] o_press_time
);
    import bcc_pkg::*;

    t_phase r_phase, n_phase;
    t_time  r_last_edge;
    t_time  r_first_press;
    t_time  r_first_release;

    logic                  r_out_valid;
    t_kind                 r_out_kind;
    logic [STAMP_BITS-1:0] r_out_press;

    t_time now, el_last, el_press, el_rel;
    logic  is_edge, is_press, is_tick, deb_drop, edge_ok, in_window, is_long;
    logic  emit, set_press, set_release;
    t_kind kind;

    assign o_pop = i_q_valid && (!r_out_valid || !i_stall);

    assign now       = i_item.stamp;
    assign el_last   = now - r_last_edge;
    assign el_press  = now - r_first_press;
    assign el_rel    = now - r_first_release;
    assign is_tick   = (i_item.action == ACT_TICK);
    assign is_press  = (i_item.action == ACT_PRESS);
    assign is_edge   = !is_tick;
    assign deb_drop  = (i_cfg.debounce_ms != '0) && (el_last < t_time'(i_cfg.debounce_ms));
    assign edge_ok   = o_pop && is_edge && !deb_drop;
    assign in_window = (el_rel <= t_time'(i_cfg.double_click_ms));
    assign is_long   = (el_press >= t_time'(i_cfg.long_press_ms));

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (o_pop && is_tick) begin
            if (r_phase == PH_WAIT && !in_window) begin
                n_phase = PH_IDLE;
            end
        end else if (edge_ok && is_press) begin
            unique case (r_phase)
                PH_IDLE:   n_phase = PH_HELD;
                PH_WAIT:   n_phase = in_window ? PH_SECOND : PH_HELD;
                PH_HELD,
                PH_SECOND: n_phase = r_phase;
            endcase
        end else if (edge_ok) begin
            unique case (r_phase)
                PH_HELD:   n_phase = is_long ? PH_IDLE : PH_WAIT;
                PH_SECOND: n_phase = PH_IDLE;
                PH_IDLE,
                PH_WAIT:   n_phase = r_phase;
            endcase
        end
    end

    // results and captures
    always_comb begin
        emit        = 1'b0;
        kind        = KIND_SINGLE;
        set_press   = 1'b0;
        set_release = 1'b0;
        if (o_pop && is_tick) begin
            emit = (r_phase == PH_WAIT) && !in_window;
        end else if (edge_ok && is_press) begin
            unique case (r_phase)
                PH_IDLE: set_press = 1'b1;
                PH_WAIT: begin
                    emit      = !in_window;
                    set_press = !in_window;
                end
                PH_HELD, PH_SECOND: emit = 1'b0;
            endcase
        end else if (edge_ok) begin
            unique case (r_phase)
                PH_HELD: begin
                    emit        = is_long;
                    kind        = KIND_LONG;
                    set_release = !is_long;
                end
                PH_SECOND: begin
                    emit = 1'b1;
                    kind = KIND_DOUBLE;
                end
                PH_IDLE, PH_WAIT: emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_last_edge     <= '0;
            r_first_press   <= '0;
            r_first_release <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (edge_ok) begin
                r_last_edge <= now;
            end
            if (set_press) begin
                r_first_press <= now;
            end
            if (set_release) begin
                r_first_release <= now;
            end
            if (o_pop) begin
                r_out_valid <= emit;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_kind  <= kind;
            r_out_press <= STAMP_BITS'(r_first_press);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_click_kind = r_out_kind;
    assign o_press_time = r_out_press;

endmodule

// ===== tb/button_click_classifier_unit_tb.sv =====
// ----------------------------------------------------------------------------
// button_click_classifier_unit_tb
// Self-checking bench for the button click classifier. Press, release and
// tick transfers go in with random gaps on the input side and random stalls
// on the result side. A gesture tracker in the bench follows debounce and
// gesture phase and queues the clicks it predicts. Each click that leaves the
// block is compared with the oldest queued one. The bench runs a short
// directed sequence at the reset settings, then random gestures under
// several register settings that include the extremes.
// ----------------------------------------------------------------------------
module button_click_classifier_unit_tb;
    import bcc_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int WAIT_MAX    = 18;
    localparam int DRAIN_WAIT  = 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 200;

    typedef struct {
        t_kind kind;
        t_time press;
    } t_click;

    class gesture_predictor;
        logic [7:0]  debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] double_click_ms;
        t_phase      phase;
        t_time       last_edge;
        t_time       first_press;
        t_time       first_release;
        t_click      due_clicks[$];
        int          errors;

        function new();
            debounce_ms     = DEBOUNCE_RST;
            long_press_ms   = LONG_PRESS_RST;
            double_click_ms = DOUBLE_CLICK_RST;
            phase           = PH_IDLE;
            last_edge       = '0;
            first_press     = '0;
            first_release   = '0;
            errors          = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] value);
            case (idx)
                CFG_DEBOUNCE:     debounce_ms     = value[7:0];
                CFG_LONG_PRESS:   long_press_ms   = value;
                CFG_DOUBLE_CLICK: double_click_ms = value;
                default: ;
            endcase
        endfunction

        function void add_click(t_kind kind, t_time press);
            t_click c;
            c.kind  = kind;
            c.press = press;
            due_clicks.push_back(c);
        endfunction

        function void take_event(logic [1:0] act, t_time now);
            t_time since;
            if (act == ACT_TICK) begin
                since = now - first_release;
                if (phase == PH_WAIT && since > double_click_ms) begin
                    phase = PH_IDLE;
                    add_click(KIND_SINGLE, first_press);
                end
                return;
            end
            if (act == ACT_UNUSED) return;
            since = now - last_edge;
            if (debounce_ms != 0 && since < debounce_ms) return;
            last_edge = now;
            if (act == ACT_PRESS) begin
                since = now - first_release;
                if (phase == PH_IDLE) begin
                    first_press = now;
                    phase       = PH_HELD;
                end else if (phase == PH_WAIT) begin
                    if (since <= double_click_ms) begin
                        phase = PH_SECOND;
                    end else begin
                        add_click(KIND_SINGLE, first_press);
                        first_press = now;
                        phase       = PH_HELD;
                    end
                end
            end else if (phase == PH_HELD) begin
                since = now - first_press;
                if (since >= long_press_ms) begin
                    phase = PH_IDLE;
                    add_click(KIND_LONG, first_press);
                end else begin
                    first_release = now;
                    phase         = PH_WAIT;
                end
            end else if (phase == PH_SECOND) begin
                phase = PH_IDLE;
                add_click(KIND_DOUBLE, first_press);
            end
        endfunction

        function void check_click(logic [1:0] kind, t_time press);
            t_click want;
            if (due_clicks.size() == 0) begin
                $display("%0t: unexpected click, kind %0d press_time %h", $time, kind, press);
                errors++;
                return;
            end
            want = due_clicks.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: click_kind expected %0d actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (press !== want.press) begin
                $display("%0t: press_time expected %h actual %h", $time, want.press, press);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_in_action = '0;
    logic [STAMP_BITS-1:0]    i_in_stamp  = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [1:0]               o_out_click_kind;
    logic [STAMP_BITS-1:0]    o_out_press_time;

    gesture_predictor clicks = new();
    bit    calm = 1'b0;
    int    items_sent = 0;
    int    rx_hold = 0;
    t_time now_ms = '0;
    t_time cur_db = t_time'(DEBOUNCE_RST);
    t_time cur_lp = t_time'(LONG_PRESS_RST);
    t_time cur_dc = t_time'(DOUBLE_CLICK_RST);

    button_click_classifier_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_action      (i_in_action),
        .i_in_stamp       (i_in_stamp),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_click_kind (o_out_click_kind),
        .o_out_press_time (o_out_press_time)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        if (calm) return 0;
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, WAIT_MAX);
        return $urandom_range(0, 2);
    endfunction

    // time step around a threshold: on it, one either side, or spread out
    function automatic t_time near(t_time x);
        case ($urandom_range(0, 5))
            0: return x;
            1: return x + 1;
            2: return (x == 0) ? x : x - 1;
            3: return $urandom_range(0, x);
            4: return x + $urandom_range(0, x + 2);
            default: return $urandom_range(0, 2 * x + 60);
        endcase
    endfunction

    function automatic t_time past_db(t_time d);
        return (d < cur_db) ? cur_db : d;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                clicks.check_click(o_out_click_kind, o_out_press_time);
                rx_hold = draw_wait();
            end else if (rx_hold != 0) begin
                rx_hold--;
            end
            i_out_stall <= (rx_hold != 0);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_item(logic [1:0] act, t_time stamp);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_action <= act;
        i_in_stamp  <= stamp;
        do @(posedge i_clk); while (o_in_stall);
        clicks.take_event(act, stamp);
        items_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (clicks.due_clicks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic load_settings(logic [7:0] db, logic [15:0] lp, logic [15:0] dc);
        logic [15:0] vals [3];
        vals = '{{8'd0, db}, lp, dc};
        for (int i = 0; i < 3; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            clicks.set_reg(t_cfg_idx'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
        cur_db = t_time'(db);
        cur_lp = t_time'(lp);
        cur_dc = t_time'(dc);
    endtask

    task automatic play_gesture();
        send_item(ACT_PRESS, now_ms);
        now_ms += past_db(near(cur_lp));
        send_item(ACT_RELEASE, now_ms);
        case ($urandom_range(0, 4))
            0: begin
                now_ms += near(cur_dc);
                send_item(ACT_TICK, now_ms);
                now_ms += near(cur_dc);
                send_item(ACT_TICK, now_ms);
            end
            1: begin
                now_ms += past_db(near(cur_dc));
                send_item(ACT_PRESS, now_ms);
                if ($urandom_range(0, 1)) send_item(ACT_TICK, now_ms + near(cur_dc));
                now_ms += past_db(near(cur_lp));
                send_item(ACT_RELEASE, now_ms);
            end
            2: send_item(ACT_TICK, now_ms - $urandom_range(1, 5000));
            default: ;
        endcase
        now_ms += past_db(near(cur_dc));
    endtask

    task automatic run_gestures(int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if ($urandom_range(0, 11) == 0) calm = !calm;
            case ($urandom_range(0, 9))
                0: begin
                    if ($urandom_range(0, 1)) begin
                        send_item(2'($urandom_range(0, 3)), $urandom());
                    end else begin
                        send_item(2'($urandom_range(0, 3)), now_ms + $urandom_range(0, 300));
                    end
                end
                1: begin
                    // contact bounce
                    repeat ($urandom_range(2, 6)) begin
                        now_ms += $urandom_range(0, cur_db + 2);
                        send_item(2'($urandom_range(0, 1)), now_ms);
                    end
                    now_ms += past_db(near(cur_dc));
                end
                default: play_gesture();
            endcase
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_settings(DEBOUNCE_RST, LONG_PRESS_RST, DOUBLE_CLICK_RST);

        send_item(ACT_PRESS, 32'd10);
        send_item(ACT_PRESS, 32'd100);
        send_item(ACT_PRESS, 32'd120);
        send_item(ACT_PRESS, 32'd200);
        send_item(ACT_RELEASE, 32'd230);
        send_item(ACT_RELEASE, 32'd300);
        send_item(ACT_TICK, 32'd700);
        send_item(ACT_UNUSED, 32'd750);
        send_item(ACT_TICK, 32'd801);
        send_item(ACT_PRESS, 32'd1000);
        send_item(ACT_RELEASE, 32'd2000);
        send_item(ACT_PRESS, 32'd3000);
        send_item(ACT_RELEASE, 32'd3100);
        send_item(ACT_PRESS, 32'd3600);
        send_item(ACT_TICK, 32'd5000);
        send_item(ACT_RELEASE, 32'd5100);
        send_item(ACT_PRESS, 32'd6000);
        send_item(ACT_RELEASE, 32'd6999);
        send_item(ACT_PRESS, 32'd7600);
        send_item(ACT_RELEASE, 32'd8000);
        send_item(ACT_TICK, 32'd100);
        send_item(ACT_PRESS, 32'hFFFF_FFC0);
        send_item(ACT_RELEASE, 32'h0000_0100);
        send_item(ACT_PRESS, 32'hFFFF_FFFF);
        send_item(ACT_RELEASE, 32'h0000_0000);
        send_item(ACT_RELEASE, 32'h0000_0040);
        send_item(ACT_TICK, 32'h7FFF_FFFF);
        settle();

        now_ms = 32'h0001_0000;
        load_settings(8'd0, 16'd0, 16'd0);
        run_gestures(PHASE_ITEMS);
        settle();
        load_settings(8'd255, 16'hFFFF, 16'hFFFF);
        run_gestures(PHASE_ITEMS);
        settle();
        load_settings(8'd1, 16'd1, 16'd1);
        run_gestures(PHASE_ITEMS);
        settle();
        repeat (2) begin
            load_settings(8'($urandom_range(0, 255)), 16'($urandom_range(0, 3000)),
                          16'($urandom_range(0, 3000)));
            run_gestures(PHASE_ITEMS);
            settle();
        end
        load_settings(DEBOUNCE_RST, LONG_PRESS_RST, DOUBLE_CLICK_RST);
        run_gestures(PHASE_ITEMS);

        calm = 1'b1;
        settle();
        repeat (2 * WAIT_MAX) @(posedge i_clk);
        if (clicks.errors == 0 && clicks.due_clicks.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_front.sv
hw/rtl/bcc_queue.sv
hw/rtl/bcc_back.sv
hw/rtl/button_click_classifier_unit.sv
tb/button_click_classifier_unit_tb.sv
